FILE: hdl/hed_pkg.sv
package hed_pkg;

	localparam int COUNT_BITS_DEF = 16;
	localparam int LIMIT_BITS = 16;
	localparam int OUT_SLOTS = 3;
	localparam int SLOT_IDX_BITS = 2;

	localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 16'hFFFF;

	localparam logic [7:0] CHAR_BSL = 8'h5C;
	localparam logic [7:0] CHAR_LX = 8'h78;
	localparam logic [7:0] CHAR_UX = 8'h58;

	localparam logic [1:0] KIND_BYTE = 2'd0;
	localparam logic [1:0] KIND_OK = 2'd1;
	localparam logic [1:0] KIND_ERR = 2'd2;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data_byte;
		logic [15:0] byte_count;
	} result_t;

	typedef struct packed {
		result_t [OUT_SLOTS-1:0] slot;
		logic [SLOT_IDX_BITS-1:0] num;
	} bundle_t;

	// bit 4 valid, bits 3:0 digit value
	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [4:0] r;
		r = '0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b1, 4'(c - 8'h57)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c - 8'h37)};
		end
		return r;
	endfunction

endpackage

FILE: hdl/hed_core.sv
module hed_core #(
	parameter int COUNT_BITS = hed_pkg::COUNT_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            step,
	input  logic [7:0]                      ch,
	input  logic                            last,
	input  logic [hed_pkg::LIMIT_BITS-1:0]  limit,
	output hed_pkg::bundle_t                bundle
);
	import hed_pkg::*;

	localparam int LW = (COUNT_BITS > LIMIT_BITS) ? COUNT_BITS : LIMIT_BITS;

	localparam logic [2:0] PH_IDLE = 3'd0;
	localparam logic [2:0] PH_BSL = 3'd1;
	localparam logic [2:0] PH_X = 3'd2;
	localparam logic [2:0] PH_DIGIT = 3'd3;
	localparam logic [2:0] PH_FULL = 3'd4;
	localparam logic [2:0] PH_ERR = 3'd5;

	logic [2:0] phase_q, phase_d;
	logic [3:0] nib_q, nib_d;
	logic [COUNT_BITS-1:0] cnt_q, cnt_d;
	logic [COUNT_BITS-1:0] eff;
	logic [LW-1:0] lim_w, cmax_w;
	logic [4:0] hx;

	assign lim_w = LW'(limit);
	assign cmax_w = LW'({COUNT_BITS{1'b1}});
	assign eff = (lim_w < cmax_w) ? lim_w[COUNT_BITS-1:0] : {COUNT_BITS{1'b1}};
	assign hx = hex_decode(ch);

	always_comb begin
		logic [2:0] ph;
		logic [3:0] nib;
		logic [COUNT_BITS-1:0] cnt;
		logic [SLOT_IDX_BITS-1:0] n;
		result_t [OUT_SLOTS-1:0] slot;
		logic [7:0] b;
		logic [LW-1:0] cnt_w;
		ph = phase_q;
		nib = nib_q;
		cnt = cnt_q;
		n = '0;
		slot = '0;
		b = '0;
		cnt_w = '0;
		case (phase_q)
			PH_IDLE: begin
				if (cnt >= eff) begin
					ph = PH_FULL;
				end else if (ch == CHAR_BSL) begin
					ph = PH_BSL;
				end else begin
					slot[n].kind = KIND_BYTE;
					slot[n].data_byte = ch;
					n = n + 1'b1;
					cnt = cnt + 1'b1;
					if (cnt >= eff) ph = PH_FULL;
				end
			end
			PH_BSL: begin
				ph = (ch == CHAR_LX || ch == CHAR_UX) ? PH_X : PH_ERR;
			end
			PH_X: begin
				if (hx[4]) begin
					nib = hx[3:0];
					ph = PH_DIGIT;
				end else begin
					ph = PH_ERR;
				end
			end
			PH_DIGIT: begin
				ph = PH_IDLE;
				b = hx[4] ? {nib, hx[3:0]} : {4'h0, nib};
				if (cnt >= eff) begin
					ph = PH_FULL;
				end else begin
					slot[n].kind = KIND_BYTE;
					slot[n].data_byte = b;
					n = n + 1'b1;
					cnt = cnt + 1'b1;
					if (cnt >= eff) ph = PH_FULL;
				end
				// non-hex char after one digit is taken again as fresh text
				if (!hx[4] && ph == PH_IDLE) begin
					if (cnt >= eff) begin
						ph = PH_FULL;
					end else if (ch == CHAR_BSL) begin
						ph = PH_BSL;
					end else begin
						slot[n].kind = KIND_BYTE;
						slot[n].data_byte = ch;
						n = n + 1'b1;
						cnt = cnt + 1'b1;
						if (cnt >= eff) ph = PH_FULL;
					end
				end
				nib = '0;
			end
			default: begin
			end
		endcase
		if (last) begin
			if (ph == PH_DIGIT) begin
				ph = PH_IDLE;
				if (cnt >= eff) begin
					ph = PH_FULL;
				end else begin
					slot[n].kind = KIND_BYTE;
					slot[n].data_byte = {4'h0, nib};
					n = n + 1'b1;
					cnt = cnt + 1'b1;
					if (cnt >= eff) ph = PH_FULL;
				end
			end
			if (ph == PH_BSL || ph == PH_X || ph == PH_ERR) begin
				slot[n].kind = KIND_ERR;
			end else begin
				cnt_w = LW'(cnt);
				slot[n].kind = KIND_OK;
				slot[n].byte_count = cnt_w[15:0];
			end
			n = n + 1'b1;
			ph = PH_IDLE;
			nib = '0;
			cnt = '0;
		end
		phase_d = ph;
		nib_d = nib;
		cnt_d = cnt;
		bundle.slot = slot;
		bundle.num = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			nib_q <= '0;
			cnt_q <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			nib_q <= nib_d;
			cnt_q <= cnt_d;
		end
	end

endmodule

FILE: hdl/hed_out.sv
module hed_out (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  hed_pkg::bundle_t  bundle,
	output logic              free,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [23:0]       m_tdata,  // data_byte, byte_count
	output logic [1:0]        m_tuser,  // kind
	output logic              m_tlast   // run_end
);
	import hed_pkg::*;

	result_t [OUT_SLOTS-1:0] slot_q;
	logic [SLOT_IDX_BITS-1:0] num_q;
	logic pop;

	assign m_tvalid = (num_q != '0);
	assign pop = m_tvalid && m_tready;
	assign free = (num_q == '0) || (num_q == SLOT_IDX_BITS'(1) && m_tready);
	assign m_tdata = {slot_q[0].byte_count, slot_q[0].data_byte};
	assign m_tuser = slot_q[0].kind;
	assign m_tlast = (num_q == SLOT_IDX_BITS'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q <= '0;
		end else if (load) begin
			num_q <= bundle.num;
		end else if (pop) begin
			num_q <= num_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			slot_q <= bundle.slot;
		end else if (pop) begin
			for (int i = 0; i < OUT_SLOTS - 1; i++) begin
				slot_q[i] <= slot_q[i+1];
			end
		end
	end

endmodule

FILE: hdl/hex_escape_decoder.sv
// channel  dir  handshake          payload
// s_*      in   s_tvalid/s_tready  tdata text_char, tlast final_char
// m_*      out  m_tvalid/m_tready  tdata data_byte+byte_count, tuser kind, tlast run_end
// cfg_*    in   cfg_we             cfg_wdata output_limit
//
// one input beat per cycle while the result register can take it: input register, one decode step, result register
// an input beat yields up to three result beats, unloaded one per cycle while m_tready is high
// the input register drains only once the result register is empty or empties
// arst_n clears the parse state, count and valids; limit resets to 65535
module hex_escape_decoder #(
	parameter int COUNT_BITS = hed_pkg::COUNT_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [7:0]                      s_tdata,   // text_char
	input  logic                            s_tlast,   // final_char
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [23:0]                     m_tdata,   // data_byte, byte_count
	output logic [1:0]                      m_tuser,   // kind
	output logic                            m_tlast,   // run_end
	input  logic                            cfg_we,
	input  logic [hed_pkg::LIMIT_BITS-1:0]  cfg_wdata
);
	import hed_pkg::*;

	logic [LIMIT_BITS-1:0] limit_q;
	logic valid_s1;
	logic [7:0] char_s1;
	logic last_s1;
	logic free;
	logic adv;
	bundle_t bundle;

	assign adv = valid_s1 && free;
	assign s_tready = !valid_s1 || free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			char_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	hed_core #(
		.COUNT_BITS(COUNT_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv),
		.ch     (char_s1),
		.last   (last_s1),
		.limit  (limit_q),
		.bundle (bundle)
	);

	hed_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (adv),
		.bundle   (bundle),
		.free     (free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

FILE: tb/hex_escape_decoder_test.sv
module hex_escape_decoder_test;

	timeunit 1ns;
	timeprecision 1ps;

	import hed_pkg::*;

	localparam int DRAIN_CYCLES = 8;
	localparam int QUIET_LIMIT = 4000;
	localparam int HOLD_CYCLES = 300;

	typedef enum logic [2:0] {
		ST_TEXT,
		ST_BSL,
		ST_X,
		ST_ONE_DIGIT,
		ST_FULL,
		ST_BAD
	} parse_state_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  data_byte;
		logic [15:0] byte_count;
		logic        run_end;
	} out_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;   // text_char
	logic        s_tlast = 1'b0; // final_char
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;        // data_byte, byte_count
	logic [1:0]  m_tuser;        // kind
	logic        m_tlast;        // run_end
	logic        cfg_we = 1'b0;
	logic [15:0] cfg_wdata = '0;

	// decoder state as predicted
	parse_state_t parse_st = ST_TEXT;
	logic [3:0]   nibble = '0;
	logic [15:0]  decoded_count = '0;
	logic [15:0]  out_limit = LIMIT_RESET;

	out_beat_t   decoded_beats[$];
	logic [7:0]  text_buf[$];
	int          errors = 0;
	int          quiet_cycles = 0;
	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	int          hold_seq = 0;
	int          hold_seen = 0;
	int          hold_left = 0;

	hex_escape_decoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int hex_val(logic [7:0] c);
		if (c >= "0" && c <= "9") begin
			return int'(c) - int'("0");
		end else if (c >= "a" && c <= "f") begin
			return int'(c) - int'("a") + 10;
		end else if (c >= "A" && c <= "F") begin
			return int'(c) - int'("A") + 10;
		end
		return -1;
	endfunction

	function automatic void add_result(logic [1:0] k, logic [7:0] b, logic [15:0] n);
		out_beat_t r;
		r.kind = k;
		r.data_byte = b;
		r.byte_count = n;
		r.run_end = 1'b0;
		decoded_beats.push_back(r);
	endfunction

	function automatic void emit_byte(logic [7:0] b);
		if (decoded_count >= out_limit) begin
			parse_st = ST_FULL;
		end else begin
			add_result(KIND_BYTE, b, 16'd0);
			decoded_count++;
			if (decoded_count >= out_limit) begin
				parse_st = ST_FULL;
			end
		end
	endfunction

	function automatic void parse_char(logic [7:0] c);
		int d;
		logic held;
		d = hex_val(c);
		held = (parse_st == ST_ONE_DIGIT);
		if (held) begin
			parse_st = ST_TEXT;
			emit_byte(d >= 0 ? {nibble, d[3:0]} : {4'h0, nibble});
			nibble = '0;
		end
		// a non-hex char after a single digit is handled again as fresh text
		if (!(held && d >= 0)) begin
			case (parse_st)
				ST_TEXT: begin
					if (decoded_count >= out_limit) begin
						parse_st = ST_FULL;
					end else if (c == CHAR_BSL) begin
						parse_st = ST_BSL;
					end else begin
						emit_byte(c);
					end
				end
				ST_BSL: begin
					parse_st = (c == CHAR_LX || c == CHAR_UX) ? ST_X : ST_BAD;
				end
				ST_X: begin
					if (d < 0) begin
						parse_st = ST_BAD;
					end else begin
						nibble = d[3:0];
						parse_st = ST_ONE_DIGIT;
					end
				end
				default: begin
				end
			endcase
		end
	endfunction

	function automatic void decode_char(logic [7:0] c, logic fin);
		int n_before;
		out_beat_t last_beat;
		n_before = decoded_beats.size();
		parse_char(c);
		if (fin) begin
			if (parse_st == ST_ONE_DIGIT) begin
				parse_st = ST_TEXT;
				emit_byte({4'h0, nibble});
			end
			if (parse_st == ST_BSL || parse_st == ST_X || parse_st == ST_BAD) begin
				add_result(KIND_ERR, 8'd0, 16'd0);
			end else begin
				add_result(KIND_OK, 8'd0, decoded_count);
			end
			parse_st = ST_TEXT;
			nibble = '0;
			decoded_count = '0;
		end
		if (decoded_beats.size() > n_before) begin
			last_beat = decoded_beats.pop_back();
			last_beat.run_end = 1'b1;
			decoded_beats.push_back(last_beat);
		end
	endfunction

	// beat monitor: results are checked before the new input is predicted
	always @(posedge clk) begin
		out_beat_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (decoded_beats.size() == 0) begin
					errors++;
					$display("%0t: unexpected result, got kind %0d byte %02h count %0d last %0b",
						$time, m_tuser, m_tdata[7:0], m_tdata[23:8], m_tlast);
				end else begin
					want = decoded_beats.pop_front();
					if (m_tuser !== want.kind || m_tdata[7:0] !== want.data_byte ||
							m_tdata[23:8] !== want.byte_count || m_tlast !== want.run_end) begin
						errors++;
						$display("%0t: mismatch, expected kind %0d byte %02h count %0d last %0b",
							$time, want.kind, want.data_byte, want.byte_count, want.run_end);
						$display("%0t:           got kind %0d byte %02h count %0d last %0b",
							$time, m_tuser, m_tdata[7:0], m_tdata[23:8], m_tlast);
					end
				end
			end
			if (s_tvalid && s_tready) begin
				decode_char(s_tdata, s_tlast);
			end
			if (cfg_we) begin
				out_limit = cfg_wdata;
			end
			if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
		end
	end

	// receiver ready, with an occasional long hold-off
	always @(posedge clk) begin
		if (hold_seq != hold_seen) begin
			hold_seen = hold_seq;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	initial begin
		while (quiet_cycles < QUIET_LIMIT) begin
			@(posedge clk);
		end
		$display("hex_escape_decoder test failed");
		$finish;
	end

	task automatic send_beat(input logic [7:0] c, input logic fin);
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(3, 1)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= c;
		s_tlast <= fin;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic send_str(input string s, input logic fin);
		for (int i = 0; i < s.len(); i++) begin
			send_beat(s[i], fin && (i == s.len() - 1));
		end
	endtask

	task automatic send_text();
		for (int i = 0; i < text_buf.size(); i++) begin
			send_beat(text_buf[i], i == text_buf.size() - 1);
		end
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (decoded_beats.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_limit(input logic [15:0] v);
		wait_idle();
		cfg_wdata <= v;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [7:0] rand_hex_digit();
		int v;
		v = $urandom_range(15);
		if (v < 10) begin
			return 8'("0" + v);
		end
		return ($urandom_range(1) ? 8'("a" + v - 10) : 8'("A" + v - 10));
	endfunction

	function automatic logic [15:0] pick_limit();
		case ($urandom_range(5))
			0: return 16'd0;
			1: return 16'($urandom_range(4, 1));
			2: return 16'($urandom_range(65535));
			3: return LIMIT_RESET;
			default: return 16'($urandom_range(12, 2));
		endcase
	endfunction

	// mostly well-formed escapes and plain chars, some malformed noise
	function automatic void build_random_text();
		int r;
		logic [7:0] c;
		text_buf.delete();
		repeat ($urandom_range(10, 1)) begin
			r = $urandom_range(99);
			if (r < 45) begin
				c = 8'($urandom_range(255));
				text_buf.push_back(c == CHAR_BSL ? 8'($urandom_range(255, 128)) : c);
			end else if (r < 80) begin
				text_buf.push_back(CHAR_BSL);
				text_buf.push_back($urandom_range(1) ? CHAR_LX : CHAR_UX);
				text_buf.push_back(rand_hex_digit());
				if ($urandom_range(9) < 7) begin
					text_buf.push_back(rand_hex_digit());
				end
			end else if (r < 90) begin
				text_buf.push_back(rand_hex_digit());
			end else begin
				text_buf.push_back(CHAR_BSL);
				if ($urandom_range(1)) begin
					text_buf.push_back($urandom_range(1) ? CHAR_LX : CHAR_UX);
				end
				text_buf.push_back(8'($urandom_range(255)));
			end
		end
	endfunction

	task automatic test_directed();
		send_beat(8'h00, 1'b0);
		send_beat(8'hFF, 1'b1);
		send_str("\\x0f\\XA9", 1'b1);
		// single digit ended by a plain char, three results on the last beat
		send_str("\\x5z", 1'b1);
		// text ends after one digit
		send_str("\\xF", 1'b1);
		// text ends after backslash, then after x
		send_str("\\", 1'b1);
		send_str("\\x", 1'b1);
		// malformed escapes, the rest is ignored
		send_str("\\qa", 1'b1);
		send_str("\\xg", 1'b1);
		send_str("\\x7\\", 1'b1);
	endtask

	task automatic test_output_limit();
		set_limit(16'd0);
		send_str("ab\\q", 1'b1);
		set_limit(16'd1);
		send_str("\\x41B\\q", 1'b1);
		// limit lowered mid-text, before a plain char and inside an escape
		set_limit(LIMIT_RESET);
		send_str("abc", 1'b0);
		set_limit(16'd2);
		send_str("d", 1'b1);
		set_limit(LIMIT_RESET);
		send_str("a\\x4", 1'b0);
		set_limit(16'd1);
		send_str("1", 1'b1);
		set_limit(LIMIT_RESET);
	endtask

	task automatic test_random_text(input int n_chars);
		int sent;
		sent = 0;
		while (sent < n_chars) begin
			if ($urandom_range(4) == 0) begin
				set_limit(pick_limit());
			end
			build_random_text();
			sent += text_buf.size();
			send_text();
		end
		set_limit(LIMIT_RESET);
	endtask

	task automatic test_backpressure();
		hold_seq++;
		repeat (8) begin
			text_buf.delete();
			repeat (6) text_buf.push_back(8'($urandom_range(91, 32)));
			send_text();
		end
		wait_idle();
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 28;
		recv_idle_pct = 69;
		test_directed();
		test_output_limit();
		test_random_text(90);

		send_idle_pct = 69;
		recv_idle_pct = 28;
		test_random_text(90);
		test_backpressure();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_text(90);

		wait_idle();
		if (errors == 0 && decoded_beats.size() == 0) begin
			$display("hex_escape_decoder test passed");
		end else begin
			$display("hex_escape_decoder test failed");
		end
		$finish;
	end

endmodule
